// ----- design/nft_pkg.sv -----
// Package with the shared constants of the name frequency table.
`default_nettype none
package nft_pkg;
  localparam int unsigned ENTRIES_DEF    = 128;
  localparam int unsigned NAME_CHARS_DEF = 49;
  localparam int unsigned COUNT_BITS_DEF = 16;

  // Result field widths and status codes.
  localparam int unsigned IDX_OUT_W = 7;
  localparam int unsigned CNT_OUT_W = 16;
  localparam int unsigned STAT_W    = 2;
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_TOO_LONG = 2'd2;
endpackage
`default_nettype wire

// ----- design/nft_front.sv -----
// Front end: accepts character beats into a two-slot pending name buffer.
`default_nettype none
module nft_front #(
  parameter int unsigned NAME_CHARS = 49,
  parameter int unsigned LW = 6,
  parameter int unsigned PA = 7
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          take,
  input  wire logic [7:0]    ch,
  input  wire logic          last,
  output logic               push,
  output logic [LW-1:0]      push_len,
  input  wire logic [PA-1:0] rd_addr,
  output logic [7:0]         rd_data_r
);
  logic [7:0]    pend_mem [2*NAME_CHARS];
  logic          slot_r;
  logic [LW-1:0] len_r;
  logic [LW-1:0] len_nxt;
  logic [PA-1:0] wr_addr;
  logic          wr_en;

  // Length saturates one past the limit so an overlong name stays marked.
  always_comb begin
    wr_en = take && (len_r < LW'(NAME_CHARS));
    len_nxt = wr_en ? len_r + LW'(1) : LW'(NAME_CHARS + 1);
    wr_addr = slot_r ? PA'(NAME_CHARS) + PA'(len_r) : PA'(len_r);
    push = take && last;
    push_len = len_nxt;
  end

  // Byte counter and slot toggle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= 1'b0;
      len_r <= '0;
    end else if (take) begin
      if (last) begin
        slot_r <= ~slot_r;
        len_r <= '0;
      end else begin
        len_r <= len_nxt;
      end
    end
  end

  // Pending name storage with a registered read port for the back end.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pend_mem[wr_addr] <= ch;
    end
    rd_data_r <= pend_mem[rd_addr];
  end
endmodule
`default_nettype wire

// ----- design/nft_queue.sv -----
// Two-entry queue of completed name lengths between front and back.
`default_nettype none
module nft_queue #(
  parameter int unsigned LW = 6
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire logic [LW-1:0] push_len,
  input  wire logic          pop,
  output logic [LW-1:0]      head_len,
  output logic               empty,
  output logic               full
);
  logic [LW-1:0] q_r [2];
  logic          wp_r;
  logic          rp_r;
  logic [1:0]    cnt_r;

  always_comb begin
    head_len = q_r[rp_r];
    empty = (cnt_r == 2'd0);
    full = (cnt_r == 2'd2);
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= push_len;
    end
  end
endmodule
`default_nettype wire

// ----- design/nft_back.sv -----
// Back end: searches the table, updates counts, appends names, tracks the mode.
`default_nettype none
module nft_back #(
  parameter int unsigned ENTRIES = 128,
  parameter int unsigned NAME_CHARS = 49,
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned LW = 6,
  parameter int unsigned PA = 7
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    q_empty,
  input  wire logic [LW-1:0]           q_len,
  output logic                         q_pop,
  output logic [PA-1:0]                pend_addr,
  input  wire logic [7:0]              pend_data,
  output logic                         out_valid,
  output logic [nft_pkg::IDX_OUT_W-1:0] out_entry_index,
  output logic [nft_pkg::CNT_OUT_W-1:0] out_entry_visits,
  output logic                         out_is_new,
  output logic [nft_pkg::IDX_OUT_W-1:0] out_best_index,
  output logic [nft_pkg::CNT_OUT_W-1:0] out_best_visits,
  output logic [nft_pkg::STAT_W-1:0]   out_status
);
  import nft_pkg::*;

  localparam int unsigned EW = $clog2(ENTRIES);
  localparam int unsigned SD = ENTRIES * NAME_CHARS;
  localparam int unsigned SA = (SD > 1) ? $clog2(SD) : 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LEN  = 4'd1;
  localparam logic [3:0] S_LENW = 4'd2;
  localparam logic [3:0] S_CMP  = 4'd3;
  localparam logic [3:0] S_CMPW = 4'd4;
  localparam logic [3:0] S_HIT  = 4'd5;
  localparam logic [3:0] S_MISS = 4'd6;
  localparam logic [3:0] S_CP   = 4'd7;
  localparam logic [3:0] S_CPW  = 4'd8;
  localparam logic [3:0] S_NEW  = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [7:0]            store_mem [SD];
  logic [LW-1:0]         lens_mem [ENTRIES];
  logic [COUNT_BITS-1:0] cnt_mem [ENTRIES];

  logic [3:0]            state_r;
  logic [LW-1:0]         len_r;
  logic [LW-1:0]         k_r;
  logic [EW:0]           e_r;
  logic [EW:0]           used_r;
  logic [SA-1:0]         base_r;
  logic [EW-1:0]         top_idx_r;
  logic [COUNT_BITS-1:0] top_cnt_r;
  logic                  rd_slot_r;
  logic [7:0]            store_q_r;
  logic [LW-1:0]         len_q_r;
  logic [COUNT_BITS-1:0] cnt_q_r;

  logic [SA-1:0]         store_addr;
  logic [EW-1:0]         e_idx;
  logic [COUNT_BITS-1:0] hit_cnt;
  logic [COUNT_BITS-1:0] note_cnt;
  logic                  take_top;
  logic                  store_we;
  logic                  cnt_we;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic [EW+IDX_OUT_W-1:0] e_ext;
  logic [EW+IDX_OUT_W-1:0] top_ext;
  logic [COUNT_BITS+CNT_OUT_W-1:0] note_ext;
  logic [COUNT_BITS+CNT_OUT_W-1:0] topc_ext;
  logic [EW+IDX_OUT_W-1:0] keep_idx_ext;
  logic [COUNT_BITS+CNT_OUT_W-1:0] keep_cnt_ext;

  // Addresses, count update and mode comparison.
  always_comb begin
    e_idx = e_r[EW-1:0];
    store_addr = base_r + SA'(k_r);
    pend_addr = rd_slot_r ? PA'(NAME_CHARS) + PA'(k_r) : PA'(k_r);
    hit_cnt = (cnt_q_r == CNT_MAX) ? cnt_q_r : cnt_q_r + COUNT_BITS'(1);
    note_cnt = (state_r == S_HIT) ? hit_cnt : COUNT_BITS'(1);
    take_top = (note_cnt > top_cnt_r) ||
               ((note_cnt == top_cnt_r) && (e_idx < top_idx_r));
    store_we = (state_r == S_CPW);
    cnt_we = (state_r == S_HIT) || (state_r == S_NEW);
    cnt_wdata = note_cnt;
    q_pop = (state_r == S_DONE);
    e_ext = {{IDX_OUT_W{1'b0}}, e_idx};
    top_ext = take_top ? {{IDX_OUT_W{1'b0}}, e_idx} : {{IDX_OUT_W{1'b0}}, top_idx_r};
    note_ext = {{CNT_OUT_W{1'b0}}, note_cnt};
    topc_ext = take_top ? {{CNT_OUT_W{1'b0}}, note_cnt} : {{CNT_OUT_W{1'b0}}, top_cnt_r};
    keep_idx_ext = {{IDX_OUT_W{1'b0}}, top_idx_r};
    keep_cnt_ext = {{CNT_OUT_W{1'b0}}, top_cnt_r};
  end

  // Table memories with registered reads.
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[store_addr] <= pend_data;
    end
    store_q_r <= store_mem[store_addr];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_NEW) begin
      lens_mem[e_idx] <= len_r;
    end
    len_q_r <= lens_mem[e_idx];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[e_idx] <= cnt_wdata;
    end
    cnt_q_r <= cnt_mem[e_idx];
  end

  // Sequencer: one length check per entry, then one byte per compare or copy step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r <= '0;
      top_idx_r <= '0;
      top_cnt_r <= '0;
      rd_slot_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            len_r <= q_len;
            e_r <= '0;
            base_r <= '0;
            if (q_len > LW'(NAME_CHARS)) begin
              out_valid <= 1'b1;
              out_entry_index <= '0;
              out_entry_visits <= '0;
              out_is_new <= 1'b0;
              out_best_index <= keep_idx_ext[IDX_OUT_W-1:0];
              out_best_visits <= keep_cnt_ext[CNT_OUT_W-1:0];
              out_status <= ST_TOO_LONG;
              state_r <= S_DONE;
            end else begin
              state_r <= S_LEN;
            end
          end
        end
        S_LEN: begin
          state_r <= (e_r == used_r) ? S_MISS : S_LENW;
        end
        S_LENW: begin
          if (len_q_r == len_r) begin
            k_r <= '0;
            state_r <= S_CMP;
          end else begin
            e_r <= e_r + (EW+1)'(1);
            base_r <= base_r + SA'(NAME_CHARS);
            state_r <= S_LEN;
          end
        end
        S_CMP: begin
          state_r <= S_CMPW;
        end
        S_CMPW: begin
          if (store_q_r != pend_data) begin
            e_r <= e_r + (EW+1)'(1);
            base_r <= base_r + SA'(NAME_CHARS);
            state_r <= S_LEN;
          end else if (k_r == len_r - LW'(1)) begin
            state_r <= S_HIT;
          end else begin
            k_r <= k_r + LW'(1);
            state_r <= S_CMP;
          end
        end
        S_HIT, S_NEW: begin
          if (take_top) begin
            top_idx_r <= e_idx;
            top_cnt_r <= note_cnt;
          end
          if (state_r == S_NEW) begin
            used_r <= used_r + (EW+1)'(1);
          end
          out_valid <= 1'b1;
          out_entry_index <= e_ext[IDX_OUT_W-1:0];
          out_entry_visits <= note_ext[CNT_OUT_W-1:0];
          out_is_new <= (state_r == S_NEW);
          out_best_index <= top_ext[IDX_OUT_W-1:0];
          out_best_visits <= topc_ext[CNT_OUT_W-1:0];
          out_status <= ST_OK;
          state_r <= S_DONE;
        end
        S_MISS: begin
          if (used_r == (EW+1)'(ENTRIES)) begin
            out_valid <= 1'b1;
            out_entry_index <= '0;
            out_entry_visits <= '0;
            out_is_new <= 1'b0;
            out_best_index <= keep_idx_ext[IDX_OUT_W-1:0];
            out_best_visits <= keep_cnt_ext[CNT_OUT_W-1:0];
            out_status <= ST_FULL;
            state_r <= S_DONE;
          end else begin
            k_r <= '0;
            state_r <= S_CP;
          end
        end
        S_CP: begin
          state_r <= S_CPW;
        end
        S_CPW: begin
          if (k_r == len_r - LW'(1)) begin
            state_r <= S_NEW;
          end else begin
            k_r <= k_r + LW'(1);
            state_r <= S_CP;
          end
        end
        S_DONE: begin
          rd_slot_r <= ~rd_slot_r;
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- design/name_frequency_table_with_mode_top.sv -----
// Top level of the name frequency table with running mode.
//
// Usage: names arrive one character beat at a time on in_ch, with in_last
// high on the final character. A beat is taken at a rising edge where start
// is high and busy is low. Each completed name gives one result beat on the
// out_ ports, marked by out_valid for exactly one cycle; the receiver must
// take it then. Character beats are taken back to back while the two-slot
// name buffer has room, so the next name streams in during a search.
// A completed name is checked against each stored entry in turn: a length
// check, then a byte-by-byte compare while the bytes match. An unmatched
// name is appended one character at a time if the table has room; then
// the result is reported. The name store has a single read port, so bytes
// are read one at a time. busy is high while both buffer slots hold names.
// Reset empties the table, the queue and the running mode; the stored
// names need no clearing, and the block takes beats right after reset.
`default_nettype none
module name_frequency_table_with_mode_top #(
  parameter int unsigned ENTRIES = nft_pkg::ENTRIES_DEF,
  parameter int unsigned NAME_CHARS = nft_pkg::NAME_CHARS_DEF,
  parameter int unsigned COUNT_BITS = nft_pkg::COUNT_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [7:0]              in_ch,
  input  wire logic                    in_last,
  output logic                         out_valid,
  output logic [nft_pkg::IDX_OUT_W-1:0] out_entry_index,
  output logic [nft_pkg::CNT_OUT_W-1:0] out_entry_visits,
  output logic                         out_is_new,
  output logic [nft_pkg::IDX_OUT_W-1:0] out_best_index,
  output logic [nft_pkg::CNT_OUT_W-1:0] out_best_visits,
  output logic [nft_pkg::STAT_W-1:0]   out_status
);
  localparam int unsigned LW = $clog2(NAME_CHARS + 2);
  localparam int unsigned PA = $clog2(2 * NAME_CHARS);

  logic          take;
  logic          push;
  logic [LW-1:0] push_len;
  logic          q_pop;
  logic [LW-1:0] q_len;
  logic          q_empty;
  logic          q_full;
  logic [PA-1:0] pend_addr;
  logic [7:0]    pend_data;

  // A beat is refused only while both name slots are owned by the back end.
  assign busy = q_full;
  assign take = start && !q_full;

  nft_front #(.NAME_CHARS(NAME_CHARS), .LW(LW), .PA(PA)) u_front (
    .clk(clk), .rst_n(rst_n), .take(take), .ch(in_ch), .last(in_last),
    .push(push), .push_len(push_len), .rd_addr(pend_addr), .rd_data_r(pend_data)
  );

  nft_queue #(.LW(LW)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_len(push_len), .pop(q_pop),
    .head_len(q_len), .empty(q_empty), .full(q_full)
  );

  nft_back #(
    .ENTRIES(ENTRIES), .NAME_CHARS(NAME_CHARS), .COUNT_BITS(COUNT_BITS),
    .LW(LW), .PA(PA)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_len(q_len), .q_pop(q_pop),
    .pend_addr(pend_addr), .pend_data(pend_data), .out_valid(out_valid),
    .out_entry_index(out_entry_index), .out_entry_visits(out_entry_visits),
    .out_is_new(out_is_new), .out_best_index(out_best_index),
    .out_best_visits(out_best_visits), .out_status(out_status)
  );
endmodule
`default_nettype wire

// ----- tb/sv/tb_name_frequency_table_with_mode_top.sv -----
// Self-checking testbench for the name frequency table with running mode.
`default_nettype none
module tb_name_frequency_table_with_mode_top;
  import nft_pkg::*;

  localparam int unsigned ENTRIES    = ENTRIES_DEF;
  localparam int unsigned NAME_CHARS = NAME_CHARS_DEF;
  localparam int unsigned CNT_MAX    = (1 << COUNT_BITS_DEF) - 1;
  localparam int unsigned POOL_SIZE  = 256;
  localparam int unsigned MAX_LEN    = 63;

  // One expected result beat.
  typedef struct packed {
    logic [IDX_OUT_W-1:0] entry_index;
    logic [CNT_OUT_W-1:0] entry_visits;
    logic                 is_new;
    logic [IDX_OUT_W-1:0] best_index;
    logic [CNT_OUT_W-1:0] best_visits;
    logic [STAT_W-1:0]    status;
  } tally_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [7:0]           in_ch;
  logic                 in_last;
  logic                 out_valid;
  logic [IDX_OUT_W-1:0] out_entry_index;
  logic [CNT_OUT_W-1:0] out_entry_visits;
  logic                 out_is_new;
  logic [IDX_OUT_W-1:0] out_best_index;
  logic [CNT_OUT_W-1:0] out_best_visits;
  logic [STAT_W-1:0]    out_status;

  name_frequency_table_with_mode_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_ch            (in_ch),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_entry_index  (out_entry_index),
    .out_entry_visits (out_entry_visits),
    .out_is_new       (out_is_new),
    .out_best_index   (out_best_index),
    .out_best_visits  (out_best_visits),
    .out_status       (out_status)
  );

  // Shadow copy of the name table and the running mode.
  logic [7:0] known_chars [ENTRIES][NAME_CHARS];
  int unsigned known_len [ENTRIES];
  int unsigned known_visits [ENTRIES];
  int unsigned known_used;
  logic [7:0] partial_chars [NAME_CHARS];
  int unsigned partial_len;
  int unsigned mode_index;
  int unsigned mode_visits;

  // Names sent so far, kept so that later names can repeat or mutate them.
  logic [7:0] sent_chars [POOL_SIZE][MAX_LEN];
  int unsigned sent_len [POOL_SIZE];
  int unsigned sent_count;

  tally_t pending_tallies [$];
  int unsigned idle_pct;
  int unsigned name_count;
  int unsigned result_count;
  int unsigned mismatch_count;
  int unsigned full_drops;
  int unsigned long_drops;
  logic [7:0] name_buf [MAX_LEN];

  // Clock and timeout.
  always #2 clk = ~clk;

  initial begin
    #40000000;
    $display("Verification failed");
    $finish;
  end

  // Update the shadow table with one accepted character beat.
  task automatic tally_char(input logic [7:0] c, input bit lst);
    tally_t t;
    int unsigned len;
    int unsigned e;
    bit found;
    bit same;
    if (partial_len < NAME_CHARS) begin
      partial_chars[partial_len] = c;
      partial_len++;
    end else begin
      partial_len = NAME_CHARS + 1;
    end
    if (lst) begin
      len = partial_len;
      partial_len = 0;
      t = '0;
      t.status = ST_OK;
      found = 1'b0;
      if (len > NAME_CHARS) begin
        t.status = ST_TOO_LONG;
        long_drops++;
      end else begin
        for (e = 0; e < known_used && !found; e++) begin
          if (known_len[e] == len) begin
            same = 1'b1;
            for (int i = 0; i < len; i++)
              if (known_chars[e][i] != partial_chars[i]) same = 1'b0;
            if (same) begin
              found = 1'b1;
              if (known_visits[e] < CNT_MAX) known_visits[e]++;
              t.entry_index = e[IDX_OUT_W-1:0];
              t.entry_visits = known_visits[e][CNT_OUT_W-1:0];
              note_mode(e, known_visits[e]);
            end
          end
        end
        if (!found) begin
          if (known_used < ENTRIES) begin
            e = known_used;
            for (int i = 0; i < len; i++) known_chars[e][i] = partial_chars[i];
            known_len[e] = len;
            known_visits[e] = 1;
            known_used++;
            t.entry_index = e[IDX_OUT_W-1:0];
            t.entry_visits = CNT_OUT_W'(1);
            t.is_new = 1'b1;
            note_mode(e, 1);
          end else begin
            t.status = ST_FULL;
            full_drops++;
          end
        end
      end
      t.best_index = mode_index[IDX_OUT_W-1:0];
      t.best_visits = mode_visits[CNT_OUT_W-1:0];
      pending_tallies.push_back(t);
    end
  endtask

  // The earliest entry wins a tie for the most visits.
  task automatic note_mode(input int unsigned e, input int unsigned c);
    if (c > mode_visits || (c == mode_visits && e < mode_index)) begin
      mode_index = e;
      mode_visits = c;
    end
  endtask

  // Drive one character beat and wait until the block takes it.
  // busy only changes at a rising edge, so its value at the falling edge
  // is the value seen at the next rising edge.
  task automatic send_char(input logic [7:0] c, input bit lst);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    in_ch = c;
    in_last = lst;
    while (busy) @(negedge clk);
    @(posedge clk);
    tally_char(c, lst);
    @(negedge clk);
  endtask

  // Send the first len bytes of name_buf as one name and remember it.
  task automatic send_name(input int unsigned len);
    for (int i = 0; i < len; i++) send_char(name_buf[i], i == len - 1);
    name_count++;
    if (sent_count < POOL_SIZE) begin
      for (int i = 0; i < len; i++) sent_chars[sent_count][i] = name_buf[i];
      sent_len[sent_count] = len;
      sent_count++;
    end
  endtask

  task automatic fill_random(input int unsigned len);
    for (int i = 0; i < len; i++) name_buf[i] = 8'($urandom_range(255));
  endtask

  // Build a random name: a repeat, a near miss of an earlier one, or a fresh one.
  task automatic random_name(output int unsigned len);
    int unsigned pick;
    int unsigned sel;
    pick = $urandom_range(99);
    if (sent_count > 0 && pick < 50) begin
      sel = $urandom_range(sent_count - 1);
      len = sent_len[sel];
      for (int i = 0; i < len; i++) name_buf[i] = sent_chars[sel][i];
      if (pick < 10) begin
        // Near miss: one byte flipped, or one byte shorter or longer.
        case ($urandom_range(2))
          0: name_buf[$urandom_range(len - 1)] ^= 8'($urandom_range(1, 255));
          1: if (len > 1) len--;
          default: if (len < MAX_LEN) begin
            name_buf[len] = 8'($urandom_range(255));
            len++;
          end
        endcase
      end
    end else begin
      pick = $urandom_range(99);
      if (pick < 70) len = $urandom_range(1, 4);
      else if (pick < 90) len = $urandom_range(5, 20);
      else if (pick < 97) len = $urandom_range(21, NAME_CHARS);
      else len = $urandom_range(NAME_CHARS + 1, MAX_LEN);
      fill_random(len);
    end
  endtask

  // Empty table, first entry, and ties settled by insertion order.
  task automatic test_mode_ties();
    idle_pct = 0;
    name_buf[0] = 8'h41;
    send_name(1);
    name_buf[0] = 8'h42;
    send_name(1);
    send_name(1);
    name_buf[0] = 8'h41;
    send_name(1);
    name_buf[0] = 8'h42;
    send_name(1);
  endtask

  // Zero, all-ones and '#' bytes are ordinary characters.
  task automatic test_special_bytes();
    name_buf[0] = 8'h00;
    send_name(1);
    name_buf[0] = 8'hff;
    name_buf[1] = 8'h23;
    name_buf[2] = 8'h00;
    send_name(3);
    send_name(3);
    name_buf[0] = 8'h23;
    send_name(1);
  endtask

  // Names at the length limit are kept, longer ones are dropped.
  task automatic test_length_limits();
    fill_random(NAME_CHARS);
    send_name(NAME_CHARS);
    send_name(NAME_CHARS);
    name_buf[NAME_CHARS - 1] ^= 8'h80;
    send_name(NAME_CHARS);
    fill_random(NAME_CHARS + 1);
    send_name(NAME_CHARS + 1);
    fill_random(MAX_LEN);
    send_name(MAX_LEN);
    name_buf[0] = 8'h41;
    send_name(1);
  endtask

  // Random traffic with the sender idling at the given rate.
  task automatic test_random_traffic(input int unsigned pct, input int unsigned chars);
    int unsigned len;
    int unsigned sent;
    idle_pct = pct;
    sent = 0;
    while (sent < chars) begin
      random_name(len);
      send_name(len);
      sent += len;
    end
  endtask

  // Fill every slot, then check that unmatched names are dropped.
  task automatic test_table_full();
    idle_pct = 0;
    while (known_used < ENTRIES) begin
      fill_random(2);
      send_name(2);
    end
    for (int n = 0; n < 8; n++) begin
      fill_random(5);
      send_name(5);
    end
  endtask

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    tally_t want;
    tally_t got;
    if (rst_n && out_valid) begin
      got = '{out_entry_index, out_entry_visits, out_is_new,
              out_best_index, out_best_visits, out_status};
      result_count++;
      if (pending_tallies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected result beat: %p", got);
      end else begin
        want = pending_tallies.pop_front();
        if (got.entry_index !== want.entry_index
            || got.entry_visits !== want.entry_visits
            || got.is_new !== want.is_new
            || got.best_index !== want.best_index
            || got.best_visits !== want.best_visits
            || got.status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch on result %0d: expected %p, got %p",
                     result_count, want, got);
        end
      end
    end
  end

  // Reset, then run the tests in turn.
  initial begin
    int unsigned wait_cycles;
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_ch = '0;
    in_last = 1'b0;
    idle_pct = 0;
    known_used = 0;
    partial_len = 0;
    mode_index = 0;
    mode_visits = 0;
    sent_count = 0;
    name_count = 0;
    result_count = 0;
    mismatch_count = 0;
    full_drops = 0;
    long_drops = 0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    test_mode_ties();
    test_special_bytes();
    test_length_limits();
    test_random_traffic(24, 150);
    test_random_traffic(79, 150);
    test_random_traffic(0, 100);
    test_table_full();
    test_random_traffic(0, 50);
    start = 1'b0;

    // Drain outstanding results, then let the block settle.
    wait_cycles = 0;
    while (pending_tallies.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (200) @(posedge clk);
    if (pending_tallies.size() != 0) mismatch_count++;

    $display("Sent %0d names, checked %0d results, %0d mismatches.",
             name_count, result_count, mismatch_count);
    $display("Dropped as too long: %0d, dropped on a full table: %0d, entries used: %0d.",
             long_drops, full_drops, known_used);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- sim.f -----
design/nft_pkg.sv
design/nft_front.sv
design/nft_queue.sv
design/nft_back.sv
design/name_frequency_table_with_mode_top.sv
tb/sv/tb_name_frequency_table_with_mode_top.sv
